// ----- design/aorq_pkg.sv -----
// ----------------------------------------------------------------------------
// aorq_pkg: age-ordered request queue package
// Sizes, action and status codes, payload structs and control signals shared
// by the queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package aorq_pkg;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_WIDTH = 32;

	// entry index, held-count and compare widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	// actions
	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_SETAGE = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;
	localparam logic [2:0] ACT_TICK   = 3'd5;

	// result status
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]               action;
		logic [PAYLOAD_WIDTH-1:0] payload_in;
		logic [7:0]               entry_age;
		logic [4:0]               position;
		logic [7:0]               tick_amount;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [PAYLOAD_WIDTH-1:0] payload_out;
		logic [7:0]               age_out;
		logic [15:0]              time_out;
		logic [4:0]               placed_at;
		logic [4:0]               entry_count;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic execute;   // apply it to the queue and load the result register
	} ctrl_cmd_t;

endpackage

// ----- design/aorq_ctrl.sv -----
// ----------------------------------------------------------------------------
// aorq_ctrl: queue controller
// Two-state sequencer: accepts a request, then executes it as soon as the
// result register is free or being drained.
// ----------------------------------------------------------------------------
module aorq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output aorq_pkg::ctrl_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_full_q;
	logic rsp_take;

	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = rsp_full_q;
	assign rsp_take    = rsp_full_q && !rsp_stall;
	assign cmd.capture = req_valid && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC) && (!rsp_full_q || rsp_take);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.execute) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rsp_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				rsp_full_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_full_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/aorq_dp.sv -----
// ----------------------------------------------------------------------------
// aorq_dp: queue datapath
// Entry registers, held count, capacity register, request latch and result
// register. Insert search, shift and tick run across all entries at once.
// ----------------------------------------------------------------------------
module aorq_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aorq_pkg::ctrl_cmd_t  cmd,
	input  aorq_pkg::req_t       req,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_data,
	output aorq_pkg::rsp_t       rsp
);

	localparam int CW = aorq_pkg::CMP_W;
	localparam int NW = aorq_pkg::CNT_W;
	localparam int PW = aorq_pkg::PAYLOAD_WIDTH;
	localparam int D  = aorq_pkg::DEPTH;

	aorq_pkg::req_t req_q;
	aorq_pkg::rsp_t rsp_q;
	aorq_pkg::rsp_t rsp_d;

	logic [PW-1:0]                 pay_q  [D];
	logic [7:0]                    age_q  [D];
	logic [15:0]                   time_q [D];
	logic [PW-1:0]                 pay_d  [D];
	logic [7:0]                    age_d  [D];
	logic [15:0]                   time_d [D];
	logic [aorq_pkg::CNT_W-1:0]    cnt_q;
	logic [aorq_pkg::CNT_W-1:0]    cnt_d;
	logic [4:0]                    max_q;

	logic [CW-1:0]                 pos_x;
	logic [CW-1:0]                 slot_x;
	logic [CW-1:0]                 cnt_x;
	logic [CW-1:0]                 max_x;
	logic [CW-1:0]                 cap_x;
	logic [CW-1:0]                 ins_x;
	logic [CW-1:0]                 ix;
	logic [aorq_pkg::IDX_W-1:0]    idx;
	logic                          in_range;
	logic                          full;
	logic                          is_ins;
	logic [7:0]                    new_age;
	logic [16:0]                   tsum;

	assign rsp = rsp_q;

	// position zero reads as one
	assign pos_x    = (req_q.position == 5'd0) ? CW'(1) : CW'(req_q.position);
	assign slot_x   = pos_x - CW'(1);
	assign cnt_x    = CW'(cnt_q);
	assign max_x    = CW'(max_q);
	assign cap_x    = (max_x < CW'(D)) ? max_x : CW'(D);
	assign in_range = (pos_x <= cnt_x) && (slot_x < CW'(D));
	assign full     = (cnt_x >= cap_x);
	assign idx      = slot_x[aorq_pkg::IDX_W-1:0];
	assign is_ins   = (req_q.action == aorq_pkg::ACT_INSERT);
	assign new_age  = is_ins ? req_q.entry_age : 8'd0;

	// sorted insert: first held entry with a strictly greater age
	always_comb begin
		ins_x = cnt_x;
		if (is_ins) begin
			for (int i = D - 1; i >= 0; i--) begin
				if ((CW'(i) < cnt_x) && (req_q.entry_age < age_q[i])) begin
					ins_x = CW'(i);
				end
			end
		end
	end

	always_comb begin
		pay_d  = pay_q;
		age_d  = age_q;
		time_d = time_q;
		cnt_d  = cnt_q;
		ix     = '0;
		tsum   = '0;
		rsp_d  = '0;
		rsp_d.status = aorq_pkg::ST_DONE;
		unique case (req_q.action)
			aorq_pkg::ACT_APPEND, aorq_pkg::ACT_INSERT: begin
				if (full) begin
					rsp_d.status = aorq_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < D; i++) begin
						ix = CW'(i);
						if (ix == ins_x) begin
							pay_d[i]  = req_q.payload_in;
							age_d[i]  = new_age;
							time_d[i] = 16'd0;
						end else if ((ix > ins_x) && (ix <= cnt_x)) begin
							pay_d[i]  = pay_q[(i > 0) ? i - 1 : 0];
							age_d[i]  = age_q[(i > 0) ? i - 1 : 0];
							time_d[i] = time_q[(i > 0) ? i - 1 : 0];
						end
					end
					cnt_d           = cnt_q + NW'(1);
					rsp_d.placed_at = 5'(ins_x + CW'(1));
				end
			end
			aorq_pkg::ACT_READ: begin
				if (!in_range) begin
					rsp_d.status = aorq_pkg::ST_RANGE;
				end else begin
					rsp_d.payload_out = pay_q[idx];
					rsp_d.age_out     = age_q[idx];
					rsp_d.time_out    = time_q[idx];
				end
			end
			aorq_pkg::ACT_SETAGE: begin
				if (!in_range) begin
					rsp_d.status = aorq_pkg::ST_RANGE;
				end else begin
					age_d[idx] = req_q.entry_age;
				end
			end
			aorq_pkg::ACT_REMOVE: begin
				if (!in_range) begin
					rsp_d.status = aorq_pkg::ST_RANGE;
				end else begin
					rsp_d.payload_out = pay_q[idx];
					for (int i = 0; i < D; i++) begin
						ix = CW'(i);
						if ((ix >= slot_x) && ((ix + CW'(1)) < cnt_x)) begin
							pay_d[i]  = pay_q[(i < D - 1) ? i + 1 : i];
							age_d[i]  = age_q[(i < D - 1) ? i + 1 : i];
							time_d[i] = time_q[(i < D - 1) ? i + 1 : i];
						end
					end
					cnt_d = cnt_q - NW'(1);
				end
			end
			aorq_pkg::ACT_TICK: begin
				for (int i = 0; i < D; i++) begin
					if (CW'(i) < cnt_x) begin
						age_d[i] = (age_q[i] < req_q.tick_amount) ? 8'd0
							: age_q[i] - req_q.tick_amount;
						tsum = {1'b0, time_q[i]} + 17'(req_q.tick_amount);
						time_d[i] = tsum[16] ? aorq_pkg::TIME_MAX : tsum[15:0];
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = 5'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			max_q <= 5'd16;
		end else begin
			if (cmd.execute) begin
				cnt_q <= cnt_d;
			end
			if (cfg_we) begin
				max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.execute) begin
			pay_q  <= pay_d;
			age_q  <= age_d;
			time_q <= time_d;
			rsp_q  <= rsp_d;
		end
	end

endmodule

// ----- design/age_ordered_request_queue.sv -----
// ----------------------------------------------------------------------------
// age_ordered_request_queue: ordered request queue with age-sorted insert
// Up to DEPTH entries of payload, age countdown and time-in-queue counter;
// append, sorted insert, read, set age, remove and age tick, one result each.
// ----------------------------------------------------------------------------
//
//  channel | signals                     | dir | transfer when
//  --------+-----------------------------+-----+---------------------------
//  req     | req_valid, req_stall, req   | in  | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp   | out | rsp_valid && !rsp_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | in | cfg_valid && cfg_ready
//
//  Each request is latched, then executed across all entries in parallel
//  (compare, shift, tick) into the result register.
//  A new request is taken while the previous result still waits in rsp.
//  A stalled rsp holds execution of the next request, not its acceptance.
//  Reset empties the queue and sets max_entries to 16; entry storage is not
//  cleared, so no clearing pass is needed.
//  cfg_ready is always high; write max_entries only while the queue is idle.
//
module age_ordered_request_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  aorq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output aorq_pkg::rsp_t   rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [4:0]       cfg_data
);

	aorq_pkg::ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// sequencer: accept, then execute when the result register can take it
	aorq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// entries, count, capacity and result register
	aorq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

	// a transfer in always blocks the next cycle while it executes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous one executing");

	// a refused insert lands nowhere and returns no data
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == aorq_pkg::ST_FULL) |->
		(rsp.placed_at == 5'd0 && rsp.payload_out == '0))
		else $error("full status with placement or data");

	// a landed insert leaves at least as many entries as its position
	a_placed_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.placed_at != 5'd0) |->
		(rsp.status == aorq_pkg::ST_DONE && rsp.entry_count >= rsp.placed_at))
		else $error("insert placed beyond entry count");

endmodule
